### hw/rtl/incremental_pi_motor_drive_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the incremental PI motor drive
// Shared concurrent assertion forms, clocked on aclk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PI_MOTOR_DRIVE_TOP_MACROS_SVH
`define INCREMENTAL_PI_MOTOR_DRIVE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IPMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ipmd_pkg.sv
// ----------------------------------------------------------------------------
// Incremental PI motor drive package
// Widths, limits, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ipmd_pkg;

    localparam int CHANNELS_DEF       = 2;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Output clamp; the drive field is fixed at 13 bits, so the limit is too.
    localparam int OUTPUT_LIMIT = 3600;

    localparam int SPEED_W = 16;
    localparam int ERR_W   = 17;
    localparam int GAIN_W  = 16;
    localparam int DRIVE_W = 13;
    localparam int DUTY_W  = 12;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELTA_GAIN_A = 2'd0,
        REG_ERROR_GAIN_A = 2'd1,
        REG_DELTA_GAIN_B = 2'd2,
        REG_ERROR_GAIN_B = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] delta_gain;
        logic [GAIN_W-1:0] error_gain;
    } gain_pair_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] acc;
        logic signed [ERR_W-1:0]   prev_err;
    } chan_state_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      forward;
        logic [DUTY_W-1:0]         duty;
    } drive_out_t;

endpackage

`default_nettype wire

### hw/rtl/ipmd_cfg.sv
// ----------------------------------------------------------------------------
// Gain register file
// Holds the four Q8.8 gains and selects the pair for the active channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ipmd_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ipmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ipmd_pkg::GAIN_W-1:0]    cfg_wdata,
    input  wire logic                           sel_chan,
    output ipmd_pkg::gain_pair_t                gains
);
    import ipmd_pkg::*;

    logic [GAIN_W-1:0] delta_a_reg;
    logic [GAIN_W-1:0] error_a_reg;
    logic [GAIN_W-1:0] delta_b_reg;
    logic [GAIN_W-1:0] error_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_a_reg <= GAIN_W'(128);
            error_a_reg <= GAIN_W'(256);
            delta_b_reg <= GAIN_W'(128);
            error_b_reg <= GAIN_W'(256);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DELTA_GAIN_A: delta_a_reg <= cfg_wdata;
                REG_ERROR_GAIN_A: error_a_reg <= cfg_wdata;
                REG_DELTA_GAIN_B: delta_b_reg <= cfg_wdata;
                REG_ERROR_GAIN_B: error_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Channel 0 uses the A pair, every other channel the B pair.
    always_comb begin
        if (!sel_chan) begin
            gains.delta_gain = delta_a_reg;
            gains.error_gain = error_a_reg;
        end else begin
            gains.delta_gain = delta_b_reg;
            gains.error_gain = error_b_reg;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ipmd_state.sv
// ----------------------------------------------------------------------------
// Per-channel loop state
// Accumulator and previous error for each channel, cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "incremental_pi_motor_drive_top_macros.svh"

module ipmd_state #(
    parameter int CHANNELS = ipmd_pkg::CHANNELS_DEF,
    parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [IDX_W-1:0]  idx,
    output ipmd_pkg::chan_state_t  rd_state,
    input  wire logic              wr_en,
    input  wire ipmd_pkg::chan_state_t wr_state
);
    import ipmd_pkg::*;

    chan_state_t state_reg [CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                state_reg[i] <= '0;
            end
        end else if (wr_en) begin
            state_reg[idx] <= wr_state;
        end
    end

    assign rd_state = state_reg[idx];

    `IPMD_ASSERT_NEXT(a_acc_written, wr_en && aresetn,
        state_reg[$past(idx)].acc == $past(wr_state.acc),
        "accumulator update lost")
    `IPMD_ASSERT_NEXT(a_err_written, wr_en && aresetn,
        state_reg[$past(idx)].prev_err == $past(wr_state.prev_err),
        "previous error update lost")
    `IPMD_ASSERT_NOW(a_acc_bounded, 1'b1,
        (rd_state.acc <= DRIVE_W'(OUTPUT_LIMIT)) && (rd_state.acc >= -DRIVE_W'(OUTPUT_LIMIT)),
        "accumulator outside drive limit")

endmodule

`default_nettype wire

### hw/rtl/ipmd_calc.sv
// ----------------------------------------------------------------------------
// PI update datapath
// Error, incremental PI sum, truncation toward zero and output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module ipmd_calc #(
    parameter int GAIN_FRAC_BITS = ipmd_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic signed [ipmd_pkg::SPEED_W-1:0] target_speed,
    input  wire logic signed [ipmd_pkg::SPEED_W-1:0] measured_speed,
    input  wire ipmd_pkg::chan_state_t               cur_state,
    input  wire ipmd_pkg::gain_pair_t                gains,
    output ipmd_pkg::chan_state_t                    new_state,
    output ipmd_pkg::drive_out_t                     result
);
    import ipmd_pkg::*;

    localparam int DIFF_W  = ERR_W + 1;
    localparam int PD_W    = DIFF_W + GAIN_W + 1;
    localparam int PE_W    = ERR_W + GAIN_W + 1;
    localparam int ACCS_W  = DRIVE_W + GAIN_FRAC_BITS;
    localparam int SUM_W   = ((ACCS_W > PD_W) ? ACCS_W : PD_W) + 2;
    localparam logic signed [SUM_W-1:0] BIAS  = (SUM_W'(1) << GAIN_FRAC_BITS) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] LIMIT = SUM_W'(OUTPUT_LIMIT);

    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PD_W-1:0]    p_delta;
    logic signed [PE_W-1:0]    p_error;
    logic signed [SUM_W-1:0]   acc_scaled;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   quot;
    logic signed [SUM_W-1:0]   clamped;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [DRIVE_W-1:0] mag;

    assign err  = ERR_W'(target_speed) - ERR_W'(measured_speed);
    assign diff = DIFF_W'(err) - DIFF_W'(cur_state.prev_err);

    assign p_delta = PD_W'(diff) * $signed({1'b0, gains.delta_gain});
    assign p_error = PE_W'(err) * $signed({1'b0, gains.error_gain});

    assign acc_scaled = SUM_W'(cur_state.acc) <<< GAIN_FRAC_BITS;
    assign sum = acc_scaled + SUM_W'(p_delta) + SUM_W'(p_error);

    // Truncate toward zero: bias negative sums before the arithmetic shift.
    // Keep both arms signed so the shift stays arithmetic.
    assign quot = (sum + (sum[SUM_W-1] ? BIAS : SUM_W'(0))) >>> GAIN_FRAC_BITS;

    always_comb begin
        priority if (quot > LIMIT) begin
            clamped = LIMIT;
        end else if (quot < -LIMIT) begin
            clamped = -LIMIT;
        end else begin
            clamped = quot;
        end
    end

    assign drive = clamped[DRIVE_W-1:0];
    assign mag   = drive[DRIVE_W-1] ? -drive : drive;

    assign new_state.acc      = drive;
    assign new_state.prev_err = err;

    assign result.drive   = drive;
    assign result.forward = !drive[DRIVE_W-1] && (|drive);
    assign result.duty    = mag[DUTY_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/incremental_pi_motor_drive_top.sv
// ----------------------------------------------------------------------------
// Incremental PI motor drive, top level
// Two-channel velocity-form PI speed loop with a streaming in/out interface.
// ----------------------------------------------------------------------------
// One speed sample per cycle is taken in while s_tready is high; each
// produces one drive result. A sample is captured in the input register on
// acceptance; the PI update (two multiplies, a three-term sum, truncation
// and clamp) is computed from that register and lands in the result
// register, which drives m_tvalid. The accumulator and previous error of the
// channel are committed in the same edge as the result, so samples for the
// same channel may follow back to back and still see the updated state.
// Sustained rate is one transaction per cycle while m_tready stays high, set
// by the single update path between the two registers; s_tready drops only
// while a result waits on m_tready with another sample already held. Gains
// must be written through the cfg_ port only while no sample is in flight;
// the block does not enforce this. Reset sets them to 0.5 (delta) and 1.0
// (error) in Q8.8 and clears all channel state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "incremental_pi_motor_drive_top_macros.svh"

module incremental_pi_motor_drive_top #(
    parameter int CHANNELS       = ipmd_pkg::CHANNELS_DEF,
    parameter int GAIN_FRAC_BITS = ipmd_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // gain configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [ipmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ipmd_pkg::GAIN_W-1:0]    cfg_wdata,
    // speed samples
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ipmd_pkg::S_TDATA_W-1:0] s_tdata,  // target_speed, measured_speed
    input  wire logic                           s_tuser,  // channel
    // drive results
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ipmd_pkg::M_TDATA_W-1:0]      m_tdata,  // drive, forward, duty, zero pad
    output logic                                m_tuser   // out_channel
);
    import ipmd_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PAD_W = M_TDATA_W - DRIVE_W - 1 - DUTY_W;

    // input register
    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic                      in_chan_reg;
    logic signed [SPEED_W-1:0] in_target_reg;
    logic signed [SPEED_W-1:0] in_meas_reg;

    // result register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_chan_reg;
    drive_out_t                out_data_reg;

    logic                      accept;
    logic                      advance;
    logic [IDX_W-1:0]          chan_idx;
    gain_pair_t                gains;
    chan_state_t               cur_state;
    chan_state_t               new_state;
    drive_out_t                result;

    // Move the held sample forward when the result slot is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : ((m_tready) ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on their transaction, hold otherwise.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_chan_reg   <= s_tuser;
            in_target_reg <= s_tdata[SPEED_W-1:0];
            in_meas_reg   <= s_tdata[2*SPEED_W-1:SPEED_W];
        end
        if (advance) begin
            out_chan_reg <= in_chan_reg;
            out_data_reg <= result;
        end
    end

    // Channels beyond the state depth fold back by modulo; with a one-bit
    // channel that only matters for a single-channel build.
    assign chan_idx = (CHANNELS > 1) ? IDX_W'(in_chan_reg) : '0;

    ipmd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sel_chan  (in_chan_reg),
        .gains     (gains)
    );

    ipmd_state #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_state (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .idx      (chan_idx),
        .rd_state (cur_state),
        .wr_en    (advance),
        .wr_state (new_state)
    );

    ipmd_calc #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_calc (
        .target_speed   (in_target_reg),
        .measured_speed (in_meas_reg),
        .cur_state      (cur_state),
        .gains          (gains),
        .new_state      (new_state),
        .result         (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_chan_reg;
    assign m_tdata  = {PAD_W'(0), out_data_reg.duty, out_data_reg.forward, out_data_reg.drive};

    `IPMD_ASSERT_NEXT(a_advance_gives_result, advance && aresetn, m_tvalid,
        "processed sample produced no result")
    `IPMD_ASSERT_NOW(a_ready_only_when_held, !s_tready, in_valid_reg && out_valid_reg,
        "input stalled without a held sample and a waiting result")
    `IPMD_ASSERT_NOW(a_result_consistent, m_tvalid,
        (out_data_reg.forward == (!out_data_reg.drive[DRIVE_W-1] && (|out_data_reg.drive)))
        && (DRIVE_W'(out_data_reg.duty) == (out_data_reg.drive[DRIVE_W-1] ?
            -out_data_reg.drive : out_data_reg.drive)),
        "direction or duty disagrees with drive")

endmodule

`default_nettype wire
